/* rtl/core/epc_pkg.sv */
`timescale 1ns / 1ps

package epc_pkg;

   // pipeline depth from an accepted request to its response register
   localparam int unsigned PIPE_DEPTH = 7;

   // seconds to days: (secs >> 7) / 675 by exact reciprocal, 25-bit dividend
   localparam int unsigned DAY_SHIFT = 35;
   localparam logic [25:0] DAY_RECIP = 26'd50903317;
   localparam logic [9:0]  DAY_DIV_HI = 10'd675;

   // days to four-year cycles: days / 1461, 16-bit dividend
   localparam int unsigned CYCLE_SHIFT = 27;
   localparam logic [16:0] CYCLE_RECIP = 17'd91868;
   localparam logic [10:0] CYCLE_DAYS = 11'd1461;

   // day offsets where the second, third and fourth year of a cycle begin
   localparam logic [10:0] YEAR1_START = 11'd365;
   localparam logic [10:0] YEAR2_START = 11'd730;
   localparam logic [10:0] YEAR3_START = 11'd1096;
   localparam logic [11:0] EPOCH_YEAR = 12'd1970;

   // time of day to hours: (tod >> 4) / 225, 13-bit dividend
   localparam int unsigned HOUR_SHIFT = 21;
   localparam logic [13:0] HOUR_RECIP = 14'd9321;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

   // seconds of the hour to minutes: (x >> 2) / 15, 10-bit dividend
   localparam int unsigned MIN_SHIFT = 14;
   localparam logic [10:0] MIN_RECIP = 11'd1093;
   localparam logic [5:0]  SECS_PER_MIN = 6'd60;

   // first day of each month within a common year, january first
   localparam logic [8:0] MONTH_START [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   // first day of month idx (0 is january), one later from march in a leap year
   function automatic logic [8:0] month_first_day(input logic [3:0] idx, input logic leap);
      logic [8:0] base;
      base = MONTH_START[idx];
      if (leap && (idx >= 4'd2)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

/* rtl/core/epc_day_split.sv */
`timescale 1ns / 1ps

module epc_day_split (
   input  logic        clock,
   input  logic        advance,
   input  logic [31:0] secs_in,
   output logic [5:0]  cycle_out,
   output logic [10:0] day_of_cycle_out,
   output logic [16:0] tod_out
);

   logic [31:0] s1_secs_ff, s1_secs_in;
   logic [50:0] s1_prod_ff, s1_prod_in;

   logic [31:0] s2_secs_ff;
   logic [15:0] s2_days_ff, s2_days_in;
   logic [25:0] s2_hi_ff, s2_hi_in;
   logic [32:0] s2_cyc_ff, s2_cyc_in;

   logic [5:0]  s3_cycle_ff, s3_cycle_in;
   logic [10:0] s3_doc_ff, s3_doc_in;
   logic [16:0] s3_tod_ff, s3_tod_in;

   logic [16:0] cyc_days;
   logic [15:0] doc_full;
   logic [24:0] tod_hi;

   // stage 1: reciprocal product for whole days
   always_comb begin
      s1_secs_in = secs_in;
      s1_prod_in = 51'(secs_in[31:7]) * 51'(epc_pkg::DAY_RECIP);
   end

   // stage 2: day count, day back-product and cycle reciprocal product
   always_comb begin
      s2_days_in = s1_prod_ff[50:epc_pkg::DAY_SHIFT];
      s2_hi_in   = 26'(s2_days_in) * 26'(epc_pkg::DAY_DIV_HI);
      s2_cyc_in  = 33'(s2_days_in) * 33'(epc_pkg::CYCLE_RECIP);
   end

   // stage 3: time of day and day offset within the four-year cycle
   always_comb begin
      s3_cycle_in = s2_cyc_ff[32:epc_pkg::CYCLE_SHIFT];
      cyc_days    = 17'(s3_cycle_in) * 17'(epc_pkg::CYCLE_DAYS);
      doc_full    = s2_days_ff - cyc_days[15:0];
      s3_doc_in   = doc_full[10:0];
      tod_hi      = s2_secs_ff[31:7] - s2_hi_ff[24:0];
      s3_tod_in   = {tod_hi[9:0], s2_secs_ff[6:0]};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_secs_ff  <= s1_secs_in;
         s1_prod_ff  <= s1_prod_in;
         s2_secs_ff  <= s1_secs_ff;
         s2_days_ff  <= s2_days_in;
         s2_hi_ff    <= s2_hi_in;
         s2_cyc_ff   <= s2_cyc_in;
         s3_cycle_ff <= s3_cycle_in;
         s3_doc_ff   <= s3_doc_in;
         s3_tod_ff   <= s3_tod_in;
      end
   end

   assign cycle_out        = s3_cycle_ff;
   assign day_of_cycle_out = s3_doc_ff;
   assign tod_out          = s3_tod_ff;

endmodule

/* rtl/core/epc_date.sv */
`timescale 1ns / 1ps

module epc_date (
   input  logic        clock,
   input  logic        advance,
   input  logic [5:0]  cycle_in,
   input  logic [10:0] day_of_cycle_in,
   output logic [11:0] year_out,
   output logic [3:0]  month_out,
   output logic [4:0]  day_out
);

   logic [11:0] s4_year_ff, s4_year_in;
   logic [8:0]  s4_doy_ff, s4_doy_in;
   logic        s4_leap_ff, s4_leap_in;

   logic [11:0] s5_year_ff;
   logic [3:0]  s5_month_ff, s5_month_in;
   logic [4:0]  s5_day_ff, s5_day_in;

   logic [11:0] s6_year_ff;
   logic [3:0]  s6_month_ff;
   logic [4:0]  s6_day_ff;

   logic [11:0] s7_year_ff;
   logic [3:0]  s7_month_ff;
   logic [4:0]  s7_day_ff;

   logic [1:0]  year_off;
   logic [10:0] year_base;
   logic [10:0] doy_full;
   logic [3:0]  month_idx;
   logic [8:0]  day_full;

   // stage 4: year within the cycle and day of year
   always_comb begin
      if (day_of_cycle_in >= epc_pkg::YEAR3_START) begin
         year_off  = 2'd3;
         year_base = epc_pkg::YEAR3_START;
      end else if (day_of_cycle_in >= epc_pkg::YEAR2_START) begin
         year_off  = 2'd2;
         year_base = epc_pkg::YEAR2_START;
      end else if (day_of_cycle_in >= epc_pkg::YEAR1_START) begin
         year_off  = 2'd1;
         year_base = epc_pkg::YEAR1_START;
      end else begin
         year_off  = 2'd0;
         year_base = 11'd0;
      end
      doy_full   = day_of_cycle_in - year_base;
      s4_doy_in  = doy_full[8:0];
      // third year of each cycle is the one divisible by four
      s4_leap_in = (year_off == 2'd2);
      s4_year_in = epc_pkg::EPOCH_YEAR + {4'd0, cycle_in, 2'b00} + {10'd0, year_off};
   end

   // stage 5: month lookup against the month start table
   always_comb begin
      month_idx = 4'd0;
      for (int i = 1; i < 12; i++) begin
         if (s4_doy_ff >= epc_pkg::month_first_day(4'(i), s4_leap_ff)) begin
            month_idx = 4'(i);
         end
      end
      day_full    = s4_doy_ff - epc_pkg::month_first_day(month_idx, s4_leap_ff) + 9'd1;
      s5_day_in   = day_full[4:0];
      s5_month_in = month_idx + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_year_ff  <= s4_year_in;
         s4_doy_ff   <= s4_doy_in;
         s4_leap_ff  <= s4_leap_in;
         s5_year_ff  <= s4_year_ff;
         s5_month_ff <= s5_month_in;
         s5_day_ff   <= s5_day_in;
         s6_year_ff  <= s5_year_ff;
         s6_month_ff <= s5_month_ff;
         s6_day_ff   <= s5_day_ff;
         s7_year_ff  <= s6_year_ff;
         s7_month_ff <= s6_month_ff;
         s7_day_ff   <= s6_day_ff;
      end
   end

   assign year_out  = s7_year_ff;
   assign month_out = s7_month_ff;
   assign day_out   = s7_day_ff;

endmodule

/* rtl/core/epc_clock.sv */
`timescale 1ns / 1ps

module epc_clock (
   input  logic        clock,
   input  logic        advance,
   input  logic [16:0] tod_in,
   output logic [4:0]  hour_out,
   output logic [5:0]  minute_out,
   output logic [5:0]  second_out
);

   logic [16:0] s4_tod_ff;
   logic [26:0] s4_prod_ff, s4_prod_in;

   logic [4:0]  s5_hour_ff, s5_hour_in;
   logic [11:0] s5_rem_ff, s5_rem_in;

   logic [4:0]  s6_hour_ff;
   logic [11:0] s6_rem_ff;
   logic [20:0] s6_prod_ff, s6_prod_in;

   logic [4:0]  s7_hour_ff;
   logic [5:0]  s7_min_ff, s7_min_in;
   logic [5:0]  s7_sec_ff, s7_sec_in;

   logic [5:0]  hour_wide;
   logic [16:0] hour_secs;
   logic [16:0] rem_full;
   logic [6:0]  min_wide;
   logic [11:0] min_secs;
   logic [11:0] sec_full;

   // stage 4: reciprocal product for hours
   assign s4_prod_in = 27'(tod_in[16:4]) * 27'(epc_pkg::HOUR_RECIP);

   // stage 5: hour and seconds left within the hour
   always_comb begin
      hour_wide  = s4_prod_ff[26:epc_pkg::HOUR_SHIFT];
      s5_hour_in = hour_wide[4:0];
      hour_secs  = 17'(s5_hour_in) * 17'(epc_pkg::SECS_PER_HOUR);
      rem_full   = s4_tod_ff - hour_secs;
      s5_rem_in  = rem_full[11:0];
   end

   // stage 6: reciprocal product for minutes
   assign s6_prod_in = 21'(s5_rem_ff[11:2]) * 21'(epc_pkg::MIN_RECIP);

   // stage 7: minute and second
   always_comb begin
      min_wide  = s6_prod_ff[20:epc_pkg::MIN_SHIFT];
      s7_min_in = min_wide[5:0];
      min_secs  = 12'(s7_min_in) * 12'(epc_pkg::SECS_PER_MIN);
      sec_full  = s6_rem_ff - min_secs;
      s7_sec_in = sec_full[5:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_tod_ff  <= tod_in;
         s4_prod_ff <= s4_prod_in;
         s5_hour_ff <= s5_hour_in;
         s5_rem_ff  <= s5_rem_in;
         s6_hour_ff <= s5_hour_ff;
         s6_rem_ff  <= s5_rem_ff;
         s6_prod_ff <= s6_prod_in;
         s7_hour_ff <= s6_hour_ff;
         s7_min_ff  <= s7_min_in;
         s7_sec_ff  <= s7_sec_in;
      end
   end

   assign hour_out   = s7_hour_ff;
   assign minute_out = s7_min_ff;
   assign second_out = s7_sec_ff;

endmodule

/* rtl/core/epoch_seconds_to_calendar.sv */
`timescale 1ns / 1ps
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into year,
// month, day, hour, minute and second. Every year divisible by four is a
// leap year, so dates are exact through 2099.
// Request channel: req_valid / req_stall with req_epoch_seconds. A beat is
// taken on a rising edge with req_valid high and req_stall low.
// Response channel: rsp_valid / rsp_stall with the six calendar fields.
// The seven register stages are day split by reciprocal multiply, day
// back-product, cycle split, year select and hour multiply, month lookup,
// minute multiply and output. Throughput is one beat per cycle while no
// response is held under rsp_stall.
// A stall that holds a response freezes the whole pipeline; req_stall is
// high exactly while a response is held under rsp_stall, so nothing is lost
// or repeated. Bubbles travel with cleared valid bits.
// Reset (synchronous, active high) clears all valid bits; no beat is in
// flight afterwards and the block takes a request in the next cycle.

module epoch_seconds_to_calendar (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_cal_year,
   output logic [3:0]  rsp_cal_month,
   output logic [4:0]  rsp_cal_day,
   output logic [4:0]  rsp_hour_of_day,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [5:0]  rsp_second_of_minute
);

   logic [epc_pkg::PIPE_DEPTH-1:0] valid_ff, valid_in;
   logic        advance;
   logic [5:0]  cycle_num;
   logic [10:0] day_of_cycle;
   logic [16:0] tod;

   // whole pipeline moves unless the response register is held
   assign advance   = !(valid_ff[epc_pkg::PIPE_DEPTH-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = valid_ff[epc_pkg::PIPE_DEPTH-1];

   // valid bits follow the data stages
   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = {valid_ff[epc_pkg::PIPE_DEPTH-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   epc_day_split u_day_split (
      .clock            (clock),
      .advance          (advance),
      .secs_in          (req_epoch_seconds),
      .cycle_out        (cycle_num),
      .day_of_cycle_out (day_of_cycle),
      .tod_out          (tod)
   );

   epc_date u_date (
      .clock           (clock),
      .advance         (advance),
      .cycle_in        (cycle_num),
      .day_of_cycle_in (day_of_cycle),
      .year_out        (rsp_cal_year),
      .month_out       (rsp_cal_month),
      .day_out         (rsp_cal_day)
   );

   epc_clock u_clock (
      .clock      (clock),
      .advance    (advance),
      .tod_in     (tod),
      .hour_out   (rsp_hour_of_day),
      .minute_out (rsp_minute_of_hour),
      .second_out (rsp_second_of_minute)
   );

   // month and day stay in calendar range on every response beat
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cal_month >= 4'd1) && (rsp_cal_month <= 4'd12) &&
                    (rsp_cal_day >= 5'd1) && (rsp_cal_day <= 5'd31))
      else $error("calendar date out of range");

   // time of day fields stay in range on every response beat
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour_of_day <= 5'd23) && (rsp_minute_of_hour <= 6'd59) &&
                    (rsp_second_of_minute <= 6'd59))
      else $error("time of day out of range");

   // year stays within the span of a 32-bit second count
   a_year_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cal_year >= 12'd1970) && (rsp_cal_year <= 12'd2106))
      else $error("year out of range");

   // an accepted request shows up as a response valid bit after the full depth
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_stall) ##1 !rsp_stall ##1 !rsp_stall ##1
      !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted beat lost in pipeline");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   // clock, reset and run limits
   localparam int unsigned CLOCK_HALF = 6;
   localparam int unsigned RESET_CYCLES = 9;
   localparam int unsigned RANDOM_STAMPS = 1750;
   localparam int unsigned DRAIN_CYCLES = 2 * epc_pkg::PIPE_DEPTH + 40;
   localparam int unsigned CYCLE_LIMIT = 600000;

   // day, year, cycle, leap day and range edge stamps, plus bit patterns
   localparam logic [31:0] EDGE_STAMPS [23] = '{
      32'd0, 32'd86399, 32'd86400,
      32'd31535999, 32'd31536000,
      32'd63071999, 32'd63072000,
      32'd68169600, 32'd68255999, 32'd68256000,
      32'd94694399, 32'd94694400,
      32'd126230399, 32'd126230400,
      32'd951782400,
      32'd2147483647, 32'd2147483648,
      32'd4102444799, 32'd4107456000, 32'd4107542400,
      32'd4294967295,
      32'hAAAAAAAA, 32'h55555555
   };

   // holds the dates expected from accepted timestamps, oldest first
   class date_scoreboard;
      typedef struct packed {
         logic [11:0] year;
         logic [3:0]  month;
         logic [4:0]  day;
         logic [4:0]  hour;
         logic [5:0]  minute;
         logic [5:0]  second;
      } cal_date_type;

      localparam int unsigned SECS_PER_DAY = 86400;
      localparam int unsigned DAYS_PER_CYCLE = 1461;
      localparam int unsigned FIRST_YEAR = 1970;

      cal_date_type expected_dates [$];
      int unsigned  error_count = 0;

      function int unsigned month_length(int unsigned mon, bit leap);
         case (mon)
            2: begin
               return leap ? 29 : 28;
            end
            4, 6, 9, 11: begin
               return 30;
            end
            default: begin
               return 31;
            end
         endcase
      endfunction

      // calendar date of a timestamp; every fourth year is a leap year
      function cal_date_type date_of(logic [31:0] stamp);
         int unsigned  secs, days, tod, yr, doff, mon, acc, mlen;
         cal_date_type d;
         secs = stamp;
         days = secs / SECS_PER_DAY;
         tod = secs % SECS_PER_DAY;
         yr = FIRST_YEAR + 4 * (days / DAYS_PER_CYCLE);
         doff = days % DAYS_PER_CYCLE;
         // third year of the cycle has 366 days
         if (doff >= 1096) begin
            yr += 3;
            doff -= 1096;
         end else if (doff >= 730) begin
            yr += 2;
            doff -= 730;
         end else if (doff >= 365) begin
            yr += 1;
            doff -= 365;
         end
         // month walk, never past december
         mon = 1;
         acc = 0;
         while (mon < 12) begin
            mlen = month_length(mon, (yr % 4) == 0);
            if (acc + mlen > doff) break;
            acc += mlen;
            mon++;
         end
         d.year = yr[11:0];
         d.month = mon[3:0];
         d.day = 5'(doff - acc + 1);
         d.hour = 5'(tod / 3600);
         d.minute = 6'((tod % 3600) / 60);
         d.second = 6'(tod % 60);
         return d;
      endfunction

      function void note_timestamp(logic [31:0] stamp);
         expected_dates.push_back(date_of(stamp));
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         error_count++;
      endtask

      task compare_field(string name, int unsigned got, int unsigned want);
         if (got != want) begin
            report($sformatf("%s got %0d, expected %0d", name, got, want));
         end
      endtask

      task check_date(cal_date_type got);
         cal_date_type want;
         if (expected_dates.size() == 0) begin
            report("date beat with no timestamp outstanding");
         end else begin
            want = expected_dates.pop_front();
            compare_field("year", 32'(got.year), 32'(want.year));
            compare_field("month", 32'(got.month), 32'(want.month));
            compare_field("day", 32'(got.day), 32'(want.day));
            compare_field("hour", 32'(got.hour), 32'(want.hour));
            compare_field("minute", 32'(got.minute), 32'(want.minute));
            compare_field("second", 32'(got.second), 32'(want.second));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_cal_year;
   logic [3:0]  rsp_cal_month;
   logic [4:0]  rsp_cal_day;
   logic [4:0]  rsp_hour_of_day;
   logic [5:0]  rsp_minute_of_hour;
   logic [5:0]  rsp_second_of_minute;

   date_scoreboard sb = new;
   bit             steady_flow = 1'b0;
   int unsigned    stall_left = 0;
   int unsigned    cycle_count = 0;

   epoch_seconds_to_calendar uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_epoch_seconds    (req_epoch_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_cal_year         (rsp_cal_year),
      .rsp_cal_month        (rsp_cal_month),
      .rsp_cal_day          (rsp_cal_day),
      .rsp_hour_of_day      (rsp_hour_of_day),
      .rsp_minute_of_hour   (rsp_minute_of_hour),
      .rsp_second_of_minute (rsp_second_of_minute)
   );

   initial begin
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // idle length: mostly short, now and then long
   function automatic int unsigned idle_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // random timestamp, biased toward day edges and the top of the range
   function automatic logic [31:0] pick_stamp();
      longint unsigned days, tod, yoff, stamp;
      case ($urandom_range(0, 3))
         0: begin
            stamp = $urandom;
         end
         1: begin
            days = $urandom_range(0, 49710);
            case ($urandom_range(0, 2))
               0: tod = 0;
               1: tod = 86399;
               default: tod = $urandom_range(0, 86399);
            endcase
            stamp = days * 86400 + tod;
         end
         2: begin
            case ($urandom_range(0, 3))
               0: yoff = 0;
               1: yoff = 365;
               2: yoff = 730;
               default: yoff = 1096;
            endcase
            days = $urandom_range(0, 34) * 1461 + yoff + $urandom_range(0, 366);
            stamp = days * 86400 + $urandom_range(0, 2) - 1;
         end
         default: begin
            stamp = 32'hFFFFFFFF - $urandom_range(0, 20000000);
         end
      endcase
      return stamp[31:0];
   endfunction

   // present one timestamp beat, hold it until taken, then maybe idle
   task automatic send_timestamp(input logic [31:0] stamp);
      int unsigned gap;
      req_valid <= 1'b1;
      req_epoch_seconds <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!steady_flow && $urandom_range(0, 99) < 30) begin
         gap = idle_length();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // note each accepted timestamp
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_timestamp(req_epoch_seconds);
      end
   end

   // check accepted date beats and drive random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_date({rsp_cal_year, rsp_cal_month, rsp_cal_day,
                           rsp_hour_of_day, rsp_minute_of_hour, rsp_second_of_minute});
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (!steady_flow && $urandom_range(0, 99) < 20) begin
            stall_left = idle_length() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed edges, first back to back
      steady_flow = 1'b1;
      foreach (EDGE_STAMPS[i]) send_timestamp(EDGE_STAMPS[i]);
      steady_flow = 1'b0;
      foreach (EDGE_STAMPS[i]) send_timestamp(EDGE_STAMPS[i]);

      // random stamps, with stretches of full rate
      for (int unsigned n = 0; n < RANDOM_STAMPS; n++) begin
         steady_flow = (n % 500) < 120;
         send_timestamp(pick_stamp());
      end
      req_valid <= 1'b0;
      steady_flow = 1'b0;

      // drain
      while (sb.expected_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/epc_pkg.sv
rtl/core/epc_day_split.sv
rtl/core/epc_date.sv
rtl/core/epc_clock.sv
rtl/core/epoch_seconds_to_calendar.sv
sim/testbench.sv
